/* src/esfa_pkg.sv */
// ----------------------------------------------------------------------------
// esfa_pkg
// Shared constants and the sine table function for the structure
// factor accumulator.
// ----------------------------------------------------------------------------
package esfa_pkg;

   localparam int NumVectorsDefault = 64;
   localparam int SineBitsDefault   = 12;

   localparam int WaveWidth  = 10;
   localparam int PosWidth   = 16;
   localparam int ValWidth   = 16;
   localparam int SumWidth   = 48;
   localparam int CountWidth = 7;

   localparam logic [1:0] CmdLoad   = 2'd0;
   localparam logic [1:0] CmdAccum  = 2'd1;
   localparam logic [1:0] CmdReadout = 2'd2;

   localparam logic [1:0] RegChargeOn = 2'd0;
   localparam logic [1:0] RegDipoleOn = 2'd1;
   localparam logic [1:0] RegActive   = 2'd2;

   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
   localparam logic [63:0] Q30One    = 64'd1 << 30;
   localparam int          TwoPiQ16  = 411775;

   // ceil(2^40 / k); exact floor division for any dividend below 2^32
   localparam int          RecipShift = 40;
   localparam logic [127:0] Recip110 = ((128'd1 << 40) + 128'd109) / 128'd110;
   localparam logic [127:0] Recip72  = ((128'd1 << 40) + 128'd71) / 128'd72;
   localparam logic [127:0] Recip42  = ((128'd1 << 40) + 128'd41) / 128'd42;
   localparam logic [127:0] Recip20  = ((128'd1 << 40) + 128'd19) / 128'd20;
   localparam logic [127:0] Recip6   = ((128'd1 << 40) + 128'd5) / 128'd6;

   // quarter-wave sine sample r of 2^qbits, Q1.15; evaluated at elaboration
   function automatic logic [15:0] quarter_sine(input logic [63:0] r, input int qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      logic [127:0] recip [5];
      recip[0] = Recip110;
      recip[1] = Recip72;
      recip[2] = Recip42;
      recip[3] = Recip20;
      recip[4] = Recip6;
      x  = (r * HalfPiQ30) >> qbits;
      x2 = (x * x) >> 30;
      p  = Q30One;
      for (int i = 0; i < 5; i++) begin
         p = Q30One - 64'((128'((x2 * p) >> 30) * recip[i]) >> RecipShift);
      end
      s = (x * p) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

endpackage

/* src/ewald_structure_factor_accumulator.sv */
// ----------------------------------------------------------------------------
// ewald_structure_factor_accumulator
// Wave vector store and per-slot complex sums in synchronous memories; each
// atom sweeps the active slots through a read-modify-write pipeline.
// ----------------------------------------------------------------------------
// A load writes the vector on acceptance. An accumulate sweeps n slots, one slot per
// cycle into a 4-stage pipe, n = active_count capped at NUM_VECTORS, then drains the
// pipe before the next request. A read out takes one slot at a time: its sums are read
// and cleared, then loaded into the output register; the next slot issues once that
// register is free or being taken. With n zero an accumulate or read out does nothing.
// Reset clears control and presets the registers; a sweep of all slots clears the sums.
module ewald_structure_factor_accumulator #(
   parameter int NUM_VECTORS     = esfa_pkg::NumVectorsDefault,
   parameter int SINE_TABLE_BITS = esfa_pkg::SineBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_cmd,
   input  logic [5:0]   req_slot,
   input  logic signed [9:0]  req_wave_x,
   input  logic signed [9:0]  req_wave_y,
   input  logic signed [9:0]  req_wave_z,
   input  logic [15:0]  req_pos_x,
   input  logic [15:0]  req_pos_y,
   input  logic [15:0]  req_pos_z,
   input  logic signed [15:0] req_charge,
   input  logic signed [15:0] req_dip_x,
   input  logic signed [15:0] req_dip_y,
   input  logic signed [15:0] req_dip_z,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [5:0]   rsp_out_slot,
   output logic signed [47:0] rsp_rho_re,
   output logic signed [47:0] rsp_rho_im,
   output logic         rsp_last,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int SlotBits = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
   localparam int TabDepth = 1 << SINE_TABLE_BITS;
   localparam int QBits    = SINE_TABLE_BITS - 2;
   localparam int QLen     = 1 << QBits;
   localparam logic signed [47:0] SumMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] SumMin = {1'b1, {47{1'b0}}};

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ACCUM, ST_READ, ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [SlotBits-1:0] slot;
   } stage_type;

   // constant sine table
   logic signed [15:0] sine_rom [TabDepth];
   always_comb begin
      for (int i = 0; i < TabDepth; i++) begin
         logic [63:0] r;
         logic [1:0]  quad;
         logic [15:0] f;
         quad = 2'(i >> QBits);
         r    = 64'(i & (QLen - 1));
         if (quad[0]) begin
            r = 64'(QLen) - r;
         end
         f = esfa_pkg::quarter_sine(r, QBits);
         sine_rom[i] = quad[1] ? -$signed(f) : $signed(f);
      end
   end

   // memories
   logic [29:0]        wave_mem [NUM_VECTORS];
   logic signed [47:0] re_mem   [NUM_VECTORS];
   logic signed [47:0] im_mem   [NUM_VECTORS];

   // configuration
   logic       charge_on_ff;
   logic       dipole_on_ff;
   logic [6:0] active_ff;

   assign pready = 1'b1;
   always_comb begin
      unique case (paddr[3:2])
         esfa_pkg::RegChargeOn: prdata = {31'd0, charge_on_ff};
         esfa_pkg::RegDipoleOn: prdata = {31'd0, dipole_on_ff};
         esfa_pkg::RegActive:   prdata = {25'd0, active_ff};
         default:               prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_on_ff <= 1'b1;
         dipole_on_ff <= 1'b0;
         active_ff    <= 7'd64;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            esfa_pkg::RegChargeOn: charge_on_ff <= pwdata[0];
            esfa_pkg::RegDipoleOn: dipole_on_ff <= pwdata[0];
            esfa_pkg::RegActive:   active_ff    <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   logic [6:0] n_use;
   assign n_use = (active_ff > 7'(NUM_VECTORS)) ? 7'(NUM_VECTORS) : active_ff;

   // control
   state_type           state_ff;
   logic [6:0]          idx_ff;
   logic [SlotBits-1:0] clr_ff;
   logic [15:0]         px_ff, py_ff, pz_ff;
   logic signed [15:0]  q_ff, dx_ff, dy_ff, dz_ff;
   stage_type           s1_ff, s2_ff, s3_ff;

   // output register
   logic                out_valid_ff;
   logic [SlotBits-1:0] out_slot_ff;
   logic signed [47:0]  out_re_ff, out_im_ff;
   logic                out_last_ff;

   logic issue;
   logic accept;
   logic rd_go;
   logic rd_s1_ff;
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // read-out pipeline may advance only if output register will be free
   // sweep issues when no entry is in flight ahead of the output
   assign rd_go = (state_ff == ST_READ) && !s1_ff.valid && !s2_ff.valid && !rd_s1_ff
                  && (!out_valid_ff || rsp_ready);
   assign issue = (state_ff == ST_ACCUM) || rd_go;

   // stage 1: memory read (wave and sums)
   logic [29:0]        w1_ff;
   logic signed [47:0] r1_ff, i1_ff;
   // stage 2: phase and dot products
   logic [15:0]        phi2_ff;
   logic signed [47:0] muk2_ff;
   logic signed [47:0] r2_ff, i2_ff;
   // stage 3: products
   logic signed [47:0] dre3_ff, dim3_ff, r3_ff, i3_ff;

   logic signed [9:0] kx, ky, kz;
   assign kx = w1_ff[29:20];
   assign ky = w1_ff[19:10];
   assign kz = w1_ff[9:0];

   logic [15:0] phi_in;
   logic signed [47:0] sdot, muk_in;
   always_comb begin
      phi_in = 16'($signed(kx) * $signed({1'b0, px_ff}) + $signed(ky) * $signed({1'b0, py_ff})
               + $signed(kz) * $signed({1'b0, pz_ff}));
      sdot   = 48'(kx) * 48'(dx_ff) + 48'(ky) * 48'(dy_ff) + 48'(kz) * 48'(dz_ff);
      muk_in = (sdot * 48'sd411775 + 48'sd32768) >>> 16;
   end

   logic [SINE_TABLE_BITS-1:0] tidx, cidx;
   logic signed [15:0] sn, cs;
   logic signed [47:0] dre_in, dim_in;
   always_comb begin
      tidx = phi2_ff[15 -: SINE_TABLE_BITS];
      cidx = tidx + SINE_TABLE_BITS'(QLen);
      sn = sine_rom[tidx];
      cs = sine_rom[cidx];
      dre_in = '0;
      dim_in = '0;
      if (charge_on_ff) begin
         dre_in = dre_in + 48'(q_ff) * 48'(cs);
         dim_in = dim_in + 48'(q_ff) * 48'(sn);
      end
      if (dipole_on_ff) begin
         dre_in = dre_in - muk2_ff * 48'(sn);
         dim_in = dim_in + muk2_ff * 48'(cs);
      end
   end

   logic signed [48:0] sre, sim;
   logic signed [47:0] nre, nim;
   always_comb begin
      sre = 49'(r3_ff) + 49'(dre3_ff);
      sim = 49'(i3_ff) + 49'(dim3_ff);
      nre = (sre > 49'(SumMax)) ? SumMax : (sre < 49'(SumMin)) ? SumMin : sre[47:0];
      nim = (sim > 49'(SumMax)) ? SumMax : (sim < 49'(SumMin)) ? SumMin : sim[47:0];
   end

   logic [SlotBits-1:0] rd_addr;
   assign rd_addr = idx_ff[SlotBits-1:0];

   // forwarding: a later slot never equals an in-flight slot within one atom,
   // but across atoms the pipeline is drained before the next request
   always_ff @(posedge clock) begin
      if (issue) begin
         w1_ff <= wave_mem[rd_addr];
         r1_ff <= re_mem[rd_addr];
         i1_ff <= im_mem[rd_addr];
      end
      phi2_ff <= phi_in;
      muk2_ff <= muk_in;
      r2_ff   <= r1_ff;
      i2_ff   <= i1_ff;
      dre3_ff <= dre_in;
      dim3_ff <= dim_in;
      r3_ff   <= r2_ff;
      i3_ff   <= i2_ff;
      if (accept && req_cmd == esfa_pkg::CmdLoad && 7'(req_slot) < 7'(NUM_VECTORS)) begin
         wave_mem[req_slot[SlotBits-1:0]] <= {req_wave_x, req_wave_y, req_wave_z};
      end
      if (state_ff == ST_CLEAR) begin
         re_mem[clr_ff] <= '0;
         im_mem[clr_ff] <= '0;
      end else if (s3_ff.valid) begin
         re_mem[s3_ff.slot] <= nre;
         im_mem[s3_ff.slot] <= nim;
      end else if (rd_go) begin
         re_mem[rd_addr] <= '0;
         im_mem[rd_addr] <= '0;
      end
      if (accept) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         pz_ff <= req_pos_z;
         q_ff  <= req_charge;
         dx_ff <= req_dip_x;
         dy_ff <= req_dip_y;
         dz_ff <= req_dip_z;
      end
   end

   // control and read-out path: r1/i1 hold the read sums, rd_s1_ff loads the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         clr_ff       <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         rd_s1_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff    <= '{valid: (state_ff == ST_ACCUM), slot: rd_addr};
         rd_s1_ff <= rd_go;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
         if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (rd_s1_ff) begin
            out_valid_ff <= 1'b1;
            out_slot_ff  <= idx_ff[SlotBits-1:0] - 1'b1;
            out_re_ff    <= r1_ff;
            out_im_ff    <= i1_ff;
            out_last_ff  <= (idx_ff == n_use);
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == NUM_VECTORS - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept && n_use != 7'd0) begin
                  if (req_cmd == esfa_pkg::CmdAccum) begin
                     state_ff <= ST_ACCUM;
                  end else if (req_cmd == esfa_pkg::CmdReadout) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_ACCUM: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == n_use) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_READ: begin
               if (rd_go) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (rd_s1_ff && idx_ff == n_use) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!s1_ff.valid && !s2_ff.valid && !s3_ff.valid && !rd_s1_ff
                   && (!out_valid_ff || rsp_ready)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_slot = 6'(out_slot_ff);
   assign rsp_rho_re   = out_re_ff;
   assign rsp_rho_im   = out_im_ff;
   assign rsp_last     = out_last_ff;

endmodule

/* test/esfa_sum_checker.sv */
// ----------------------------------------------------------------------------
// esfa_sum_checker
// Watches the request, response and register ports of the structure factor
// accumulator, predicts every read-out sum and compares field by field.
// ----------------------------------------------------------------------------
module esfa_sum_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [5:0]          req_slot,
   input  logic signed [9:0]   req_wave_x,
   input  logic signed [9:0]   req_wave_y,
   input  logic signed [9:0]   req_wave_z,
   input  logic [15:0]         req_pos_x,
   input  logic [15:0]         req_pos_y,
   input  logic [15:0]         req_pos_z,
   input  logic signed [15:0]  req_charge,
   input  logic signed [15:0]  req_dip_x,
   input  logic signed [15:0]  req_dip_y,
   input  logic signed [15:0]  req_dip_z,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [5:0]          rsp_out_slot,
   input  logic signed [47:0]  rsp_rho_re,
   input  logic signed [47:0]  rsp_rho_im,
   input  logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output int                  errors,
   output int                  pending,
   output int                  atoms_seen,
   output int                  sums_checked
);

   localparam int Slots = 64;
   localparam int LutSize = 4096;
   localparam int QuarterLen = 1024;
   localparam longint SatHi = (64'sd1 <<< 47) - 1;
   localparam longint SatLo = -(64'sd1 <<< 47);

   typedef struct {
      logic [5:0]  slot;
      logic [47:0] re;
      logic [47:0] im;
      logic        last;
   } slot_sum_type;

   slot_sum_type sums_due[$];
   longint    sine_lut [LutSize];
   longint    wave_k [Slots][3];
   longint    rho_re_acc [Slots];
   longint    rho_im_acc [Slots];
   bit        use_charge;
   bit        use_dipole;
   int        slots_live;

   function automatic longint quarter_wave(longint unsigned r);
      longint unsigned x, x2, p, s, v;
      longint unsigned dv [5];
      dv = '{110, 72, 42, 20, 6};
      x  = (r * 64'd1686629713) >> 10;
      x2 = (x * x) >> 30;
      p  = 64'd1 << 30;
      foreach (dv[k]) p = (64'd1 << 30) - (((x2 * p) >> 30) / dv[k]);
      s = (x * p) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      return (v > 32767) ? 32767 : longint'(v);
   endfunction

   function automatic longint clamp48(longint v);
      if (v > SatHi) return SatHi;
      if (v < SatLo) return SatLo;
      return v;
   endfunction

   initial begin
      int r;
      for (int i = 0; i < LutSize; i++) begin
         r = i % QuarterLen;
         if ((i / QuarterLen) % 2 == 1) r = QuarterLen - r;
         sine_lut[i] = (i >= 2 * QuarterLen) ? -quarter_wave(r) : quarter_wave(r);
      end
   end

   task automatic add_atom();
      longint phi, sn, cs, sdot, muk, dre, dim;
      int idx;
      for (int i = 0; i < slots_live; i++) begin
         phi = (wave_k[i][0] * req_pos_x + wave_k[i][1] * req_pos_y
                + wave_k[i][2] * req_pos_z) & 64'hFFFF;
         idx = int'(phi >> 4);
         sn  = sine_lut[idx];
         cs  = sine_lut[(idx + QuarterLen) % LutSize];
         dre = 0;
         dim = 0;
         if (use_charge) begin
            dre += longint'(req_charge) * cs;
            dim += longint'(req_charge) * sn;
         end
         if (use_dipole) begin
            sdot = wave_k[i][0] * req_dip_x + wave_k[i][1] * req_dip_y
                   + wave_k[i][2] * req_dip_z;
            muk  = (sdot * esfa_pkg::TwoPiQ16 + 32768) >>> 16;
            dre -= muk * sn;
            dim += muk * cs;
         end
         rho_re_acc[i] = clamp48(rho_re_acc[i] + dre);
         rho_im_acc[i] = clamp48(rho_im_acc[i] + dim);
      end
   endtask

   always @(posedge clock) begin
      slot_sum_type e;
      if (reset) begin
         sums_due.delete();
         use_charge = 1;
         use_dipole = 0;
         slots_live = 64;
         foreach (rho_re_acc[i]) begin
            rho_re_acc[i] = 0;
            rho_im_acc[i] = 0;
            wave_k[i] = '{0, 0, 0};
         end
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               esfa_pkg::RegChargeOn: use_charge = pwdata[0];
               esfa_pkg::RegDipoleOn: use_dipole = pwdata[0];
               esfa_pkg::RegActive: begin
                  slots_live = int'(pwdata[6:0]);
                  if (slots_live > Slots) slots_live = Slots;
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (sums_due.size() == 0) begin
               $error("unexpected response slot %0d", rsp_out_slot);
               errors++;
            end else begin
               e = sums_due.pop_front();
               sums_checked++;
               if (rsp_out_slot !== e.slot) begin
                  $error("out_slot expected %0d got %0d", e.slot, rsp_out_slot);
                  errors++;
               end
               if (rsp_rho_re !== e.re) begin
                  $error("rho_re expected %0d got %0d", $signed(e.re), rsp_rho_re);
                  errors++;
               end
               if (rsp_rho_im !== e.im) begin
                  $error("rho_im expected %0d got %0d", $signed(e.im), rsp_rho_im);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_cmd)
               esfa_pkg::CmdLoad: wave_k[req_slot] = '{req_wave_x, req_wave_y, req_wave_z};
               esfa_pkg::CmdAccum: begin
                  add_atom();
                  atoms_seen++;
               end
               esfa_pkg::CmdReadout: begin
                  for (int i = 0; i < slots_live; i++) begin
                     e.slot = 6'(i);
                     e.re   = rho_re_acc[i][47:0];
                     e.im   = rho_im_acc[i][47:0];
                     e.last = (i + 1 == slots_live);
                     sums_due.push_back(e);
                     rho_re_acc[i] = 0;
                     rho_im_acc[i] = 0;
                  end
               end
               default: ;
            endcase
         end
      end
      pending <= sums_due.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      atoms_seen = 0;
      sums_checked = 0;
   end
endmodule

/* test/tb_ewald_structure_factor_accumulator.sv */
// ----------------------------------------------------------------------------
// tb_ewald_structure_factor_accumulator
// Loads wave vectors, streams directed and random atoms and read-outs under
// several register settings with random idling and back-pressure; a side
// checker predicts and compares every complex sum.
// ----------------------------------------------------------------------------
module tb_ewald_structure_factor_accumulator;

   localparam logic [1:0] CmdIgnored = 2'd3;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 80;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_cmd = esfa_pkg::CmdLoad;
   logic [5:0] req_slot = 0;
   logic signed [9:0] req_wave_x = 0, req_wave_y = 0, req_wave_z = 0;
   logic [15:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] req_charge = 0, req_dip_x = 0, req_dip_y = 0, req_dip_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [5:0] rsp_out_slot;
   logic signed [47:0] rsp_rho_re, rsp_rho_im;
   logic rsp_last;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [3:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   int errors, pending, atoms_seen, sums_checked;
   int quiet_cycles = 0;
   int requests = 0;
   bit calm = 0;

   always #4 clock = ~clock;

   ewald_structure_factor_accumulator uut (.*);

   esfa_sum_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 27);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send(input logic [1:0] cmd, input int slot,
                       input int wx, input int wy, input int wz,
                       input int px, input int py, input int pz,
                       input int q, input int dx, input int dy,
                       input int dz);
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_slot <= 6'(slot);
      req_wave_x <= 10'(wx);
      req_wave_y <= 10'(wy);
      req_wave_z <= 10'(wz);
      req_pos_x <= 16'(px);
      req_pos_y <= 16'(py);
      req_pos_z <= 16'(pz);
      req_charge <= 16'(q);
      req_dip_x <= 16'(dx);
      req_dip_y <= 16'(dy);
      req_dip_z <= 16'(dz);
      do @(posedge clock); while (!req_ready);
      requests++;
   endtask

   task automatic load_wave(input int slot, input int wx, input int wy, input int wz);
      send(esfa_pkg::CmdLoad, slot, wx, wy, wz, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic atom(input int px, input int py, input int pz,
                       input int q, input int dx, input int dy, input int dz);
      send(esfa_pkg::CmdAccum, $urandom, $urandom, $urandom, $urandom, px, py, pz,
           q, dx, dy, dz);
   endtask

   task automatic readout();
      send(esfa_pkg::CmdReadout, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic configure(input bit chg, input bit dip, input int count);
      csr_write(esfa_pkg::RegChargeOn, 32'(chg));
      csr_write(esfa_pkg::RegDipoleOn, 32'(dip));
      csr_write(esfa_pkg::RegActive, 32'(count));
   endtask

   function automatic int rand_wave();
      return ($urandom_range(3) == 0) ? $urandom_range(8) - 4 : $urandom_range(1023) - 512;
   endfunction

   function automatic int rand_val();
      return ($urandom_range(3) == 0) ? $urandom_range(4095) - 2048 : $urandom_range(65535);
   endfunction

   task automatic random_phase(input int items);
      int pick;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            load_wave($urandom_range(63), rand_wave(), rand_wave(), rand_wave());
         end else if (pick < 80) begin
            atom($urandom, $urandom, $urandom, rand_val(), rand_val(), rand_val(), rand_val());
         end else if (pick < 93) begin
            readout();
         end else begin
            send(CmdIgnored, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
      readout();
      drain();
   endtask

   initial begin
      bit chg [8] = '{1, 1, 0, 0, 1, 1, 1, 0};
      bit dip [8] = '{1, 0, 1, 0, 1, 1, 1, 1};
      int cnt [8] = '{64, 1, 7, 64, 0, 127, 100, 33};
      repeat (5) @(posedge clock);
      reset <= 0;

      // every slot gets a vector before any atom sweeps it
      calm = 1;
      configure(1, 1, 64);
      load_wave(0, 0, 0, 0);
      load_wave(1, -512, -512, -512);
      load_wave(2, 511, 511, 511);
      load_wave(3, 1, 0, 0);
      for (int i = 4; i < 64; i++) load_wave(i, rand_wave(), rand_wave(), rand_wave());

      atom(0, 0, 0, 32767, 32767, 32767, 32767);
      atom(65535, 65535, 65535, -32768, -32768, -32768, -32768);
      atom(16384, 32768, 49152, 2048, -2048, 0, 1);
      send(CmdIgnored, 63, -1, -1, -1, 65535, 65535, 65535, 16'h7fff, 0, 0, 0);
      readout();
      readout();
      drain();

      // drive both signs into saturation
      configure(0, 1, 3);
      for (int i = 0; i < 18; i++) atom(0, 0, 0, 32767, 32767, 32767, 32767);
      readout();
      drain();
      calm = 0;

      for (int p = 0; p < 8; p++) begin
         calm = (p == 3);
         configure(chg[p], dip[p], cnt[p]);
         random_phase(40);
      end
      calm = 0;
      configure(1, 1, $urandom_range(1, 64));
      random_phase(20);

      $display("Covered %0d requests, %0d atoms, %0d sums checked over 11 settings.",
               requests, atoms_seen, sums_checked);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
src/esfa_pkg.sv
src/ewald_structure_factor_accumulator.sv
test/esfa_sum_checker.sv
test/tb_ewald_structure_factor_accumulator.sv
